/* src/oep_pkg.sv */
// Shared types and constants for the odd/even partition unit.
package oep_pkg;

	localparam int DEPTH = 64;
	localparam int DATA_W = 32;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_READ,
		ST_CMP,
		ST_SWAP,
		ST_FETCH,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic [ADDR_W-1:0] raddr_a;
		logic [ADDR_W-1:0] raddr_b;
	} mem_ctl_t;

endpackage

/* src/odd_even_partition_unit.sv */
// Loading: an item is taken whenever valid is high in the load state; the item marked last starts the partition.
// Partition: each pointer step reads both words (READ) and compares them (CMP); an exchange adds a write-back (SWAP).
// Emission: each result is read (FETCH), then presented (EMIT) on read port a of the buffer RAM until res_ready.
// One array is handled at a time; ready stays low from the last item to the final result.
// Reset (arst_n, asynchronous, active low) clears the count, overflow flag and sequencer.
// Top level of the odd/even partition unit.
module odd_even_partition_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	output logic               ready,
	input  logic signed [31:0] value,
	input  logic               last,
	output logic               res_valid,
	input  logic               res_ready,
	output logic signed [31:0] value_res,
	output logic               last_res,
	output logic               dropped
);

	oep_pkg::mem_ctl_t          mem_ctl;
	logic [oep_pkg::DATA_W-1:0] rdata_a;
	logic [oep_pkg::DATA_W-1:0] rdata_b;

	oep_ram #(
		.AW(oep_pkg::ADDR_W),
		.DW(oep_pkg::DATA_W)
	) u_ram (
		.clk     (clk),
		.we      (mem_ctl.we),
		.waddr   (mem_ctl.waddr),
		.wdata   (mem_ctl.wdata),
		.raddr_a (mem_ctl.raddr_a),
		.raddr_b (mem_ctl.raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	oep_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (valid),
		.ready     (ready),
		.value     (value),
		.last      (last),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.value_res (value_res),
		.last_res  (last_res),
		.dropped   (dropped),
		.rdata_a   (rdata_a),
		.rdata_b   (rdata_b),
		.mem_ctl   (mem_ctl)
	);

endmodule

/* src/oep_ram.sv */
// Generic RAM with one write port and two registered read ports.
module oep_ram #(
	parameter int AW = 6,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic [DW-1:0] rdata_a,
	output logic [DW-1:0] rdata_b
);

	logic [DW-1:0] mem_q [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

/* src/oep_ctrl.sv */
// Sequencer: load, two-pointer partition over the buffer RAM, and emission.
module oep_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid,
	output logic                       ready,
	input  logic signed [31:0]         value,
	input  logic                       last,
	output logic                       res_valid,
	input  logic                       res_ready,
	output logic signed [31:0]         value_res,
	output logic                       last_res,
	output logic                       dropped,
	input  logic [oep_pkg::DATA_W-1:0] rdata_a,
	input  logic [oep_pkg::DATA_W-1:0] rdata_b,
	output oep_pkg::mem_ctl_t          mem_ctl
);

	oep_pkg::state_t state_q, state_d;

	logic [oep_pkg::CNT_W-1:0]  cnt_q;
	logic [oep_pkg::CNT_W-1:0]  n_q;
	logic                       ovf_q;
	logic [oep_pkg::ADDR_W-1:0] l_q;
	logic [oep_pkg::ADDR_W-1:0] r_q;
	logic [oep_pkg::ADDR_W-1:0] e_q;
	logic [oep_pkg::DATA_W-1:0] swap_q;

	logic                       in_acc;
	logic                       out_acc;
	logic                       has_room;
	logic [oep_pkg::CNT_W-1:0]  cnt_next;
	logic                       is_final;

	assign in_acc   = valid && ready;
	assign out_acc  = res_valid && res_ready;
	assign has_room = cnt_q < oep_pkg::CNT_W'(oep_pkg::DEPTH);
	assign cnt_next = has_room ? cnt_q + 1'b1 : cnt_q;
	assign is_final = oep_pkg::CNT_W'(e_q) == n_q - 1'b1;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			oep_pkg::ST_LOAD: begin
				if (in_acc && last) begin
					state_d = oep_pkg::ST_READ;
				end
			end
			oep_pkg::ST_READ: begin
				state_d = (l_q < r_q) ? oep_pkg::ST_CMP : oep_pkg::ST_FETCH;
			end
			oep_pkg::ST_CMP: begin
				// Both in the wrong class: exchange them.
				if (!rdata_a[0] && rdata_b[0]) begin
					state_d = oep_pkg::ST_SWAP;
				end else begin
					state_d = oep_pkg::ST_READ;
				end
			end
			oep_pkg::ST_SWAP: begin
				state_d = oep_pkg::ST_READ;
			end
			oep_pkg::ST_FETCH: begin
				state_d = oep_pkg::ST_EMIT;
			end
			oep_pkg::ST_EMIT: begin
				if (out_acc) begin
					state_d = is_final ? oep_pkg::ST_LOAD : oep_pkg::ST_FETCH;
				end
			end
			default: begin
				state_d = oep_pkg::ST_LOAD;
			end
		endcase
	end

	// Outputs and RAM control.
	always_comb begin
		ready           = 1'b0;
		res_valid       = 1'b0;
		mem_ctl.we      = 1'b0;
		mem_ctl.waddr   = cnt_q[oep_pkg::ADDR_W-1:0];
		mem_ctl.wdata   = value;
		mem_ctl.raddr_a = l_q;
		mem_ctl.raddr_b = r_q;
		unique case (state_q)
			oep_pkg::ST_LOAD: begin
				ready      = 1'b1;
				mem_ctl.we = in_acc && has_room;
			end
			oep_pkg::ST_CMP: begin
				mem_ctl.we    = !rdata_a[0] && rdata_b[0];
				mem_ctl.waddr = l_q;
				mem_ctl.wdata = rdata_b;
			end
			oep_pkg::ST_SWAP: begin
				mem_ctl.we    = 1'b1;
				mem_ctl.waddr = r_q;
				mem_ctl.wdata = swap_q;
			end
			oep_pkg::ST_FETCH: begin
				mem_ctl.raddr_a = e_q;
			end
			oep_pkg::ST_EMIT: begin
				// Hold the address so the read data stays put while stalled.
				mem_ctl.raddr_a = e_q;
				res_valid       = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign value_res = rdata_a;
	assign last_res  = is_final;
	assign dropped   = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oep_pkg::ST_LOAD;
			cnt_q   <= '0;
			n_q     <= '0;
			ovf_q   <= 1'b0;
			l_q     <= '0;
			r_q     <= '0;
			e_q     <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				oep_pkg::ST_LOAD: begin
					if (in_acc) begin
						cnt_q <= cnt_next;
						if (!has_room) begin
							ovf_q <= 1'b1;
						end
						if (last) begin
							n_q <= cnt_next;
							l_q <= '0;
							r_q <= oep_pkg::ADDR_W'(cnt_next - 1'b1);
							e_q <= '0;
						end
					end
				end
				oep_pkg::ST_CMP: begin
					// Left odd: advance left. Otherwise, right even: step right down.
					if (rdata_a[0]) begin
						l_q <= l_q + 1'b1;
					end else if (!rdata_b[0]) begin
						r_q <= r_q - 1'b1;
					end
				end
				oep_pkg::ST_SWAP: begin
					l_q <= l_q + 1'b1;
					r_q <= r_q - 1'b1;
				end
				oep_pkg::ST_EMIT: begin
					if (out_acc) begin
						e_q <= e_q + 1'b1;
						if (is_final) begin
							cnt_q <= '0;
							ovf_q <= 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == oep_pkg::ST_CMP) begin
			swap_q <= rdata_a;
		end
	end

endmodule

/* src/oep_checker.sv */
// Port-level checks for the odd/even partition unit, bound to the top level.
module oep_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               valid,
	input logic               ready,
	input logic               last,
	input logic               res_valid,
	input logic               res_ready,
	input logic signed [31:0] value_res,
	input logic               last_res,
	input logic               dropped
);

	// Loading and emission never overlap.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ready && res_valid))
		else $error("input and result channels active together");

	// The item marked last closes the load phase.
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && ready && last) |=> !ready)
		else $error("still ready after last item");

	// Loading resumes right after the final result.
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready && last_res) |=> ready)
		else $error("not ready after final result");

	// More results follow a non-final result.
	a_more: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready && !last_res) |=> !ready)
		else $error("ready before run finished");

	// A stalled result holds its value and flags.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=>
			(res_valid && $stable(value_res) && $stable(last_res) && $stable(dropped)))
		else $error("stalled result changed");

endmodule

bind odd_even_partition_unit oep_checker u_oep_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.valid     (valid),
	.ready     (ready),
	.last      (last),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.value_res (value_res),
	.last_res  (last_res),
	.dropped   (dropped)
);

/* tb/tb_odd_even_partition_unit.sv */
`timescale 1ns / 100ps
// Testbench for the odd/even partition unit against a local two-pointer predictor.
module tb_odd_even_partition_unit;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_WORDS = 10;

	typedef struct {
		logic signed [31:0] word;
		logic               tail;
		logic               trunc;
	} out_word_t;

	logic               clk;
	logic               arst_n;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic               last;
	logic               res_valid;
	logic               res_ready;
	logic signed [31:0] value_res;
	logic               last_res;
	logic               dropped;

	// predictor state: words held for the array in progress
	logic [31:0] held_words [oep_pkg::DEPTH];
	int unsigned held_count;
	bit          held_overflow;
	out_word_t   partitioned_q [$];

	int errors;
	int arrays_sent;
	int words_sent;
	int words_checked;
	int cycles;
	int stall_left;
	bit gaps_on;

	odd_even_partition_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (valid),
		.ready     (ready),
		.value     (value),
		.last      (last),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.value_res (value_res),
		.last_res  (last_res),
		.dropped   (dropped)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// two-pointer exchange: left skips odd words, right skips even words
	task automatic reorder_held();
		int unsigned lo;
		int unsigned hi;
		logic [31:0] tmp;
		if (held_count < 2)
			return;
		lo = 0;
		hi = held_count - 1;
		while (lo < hi) begin
			while (lo < hi && held_words[lo][0])
				lo++;
			while (lo < hi && !held_words[hi][0])
				hi--;
			if (lo < hi) begin
				tmp = held_words[lo];
				held_words[lo] = held_words[hi];
				held_words[hi] = tmp;
				lo++;
				hi--;
			end
		end
	endtask

	task automatic absorb_word(input logic [31:0] v, input logic is_last);
		out_word_t w;
		if (held_count < oep_pkg::DEPTH) begin
			held_words[held_count] = v;
			held_count++;
		end else begin
			held_overflow = 1'b1;
		end
		if (is_last) begin
			reorder_held();
			for (int unsigned i = 0; i < held_count; i++) begin
				w.word = held_words[i];
				w.tail = (i + 1 == held_count);
				w.trunc = held_overflow;
				partitioned_q.push_back(w);
			end
			held_count = 0;
			held_overflow = 1'b0;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && valid && ready)
			absorb_word(value, last);
	end

	// result side back-pressure in bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			res_ready <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 3) == 0) begin
			stall_left = $urandom_range(1, 6) - 1;
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	task automatic check_result();
		out_word_t exp;
		if (partitioned_q.size() == 0) begin
			$display("%0t: result with nothing expected: value %0d last %0b dropped %0b",
				$time, value_res, last_res, dropped);
			errors++;
			return;
		end
		exp = partitioned_q.pop_front();
		words_checked++;
		if (value_res !== exp.word) begin
			$display("%0t: value_res expected %0d actual %0d", $time, exp.word, value_res);
			errors++;
		end
		if (last_res !== exp.tail) begin
			$display("%0t: last_res expected %0b actual %0b", $time, exp.tail, last_res);
			errors++;
		end
		if (dropped !== exp.trunc) begin
			$display("%0t: dropped expected %0b actual %0b", $time, exp.trunc, dropped);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			check_result();
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still expected", $time, partitioned_q.size());
			$display("odd_even_partition_unit verification failed");
			$finish;
		end
	end

	// hold valid and payload until the item is taken
	task automatic send_word(input logic signed [31:0] v, input logic is_last);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		valid <= 1'b1;
		value <= v;
		last <= is_last;
		@(posedge clk);
		while (!ready)
			@(posedge clk);
		words_sent++;
		if (is_last)
			arrays_sent++;
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000 | 32'($urandom_range(0, 1));
			1: return 32'h7FFF_FFFF - 32'($urandom_range(0, 1));
			2: return 32'($urandom_range(0, 40)) - 32'd20;
			default: return $urandom();
		endcase
	endfunction

	// bias: 0 none, 1 mostly odd, 2 mostly even
	task automatic send_array(input int n, input int bias);
		logic [31:0] w;
		for (int i = 0; i < n; i++) begin
			w = rand_word();
			if (bias == 1 && $urandom_range(0, 3) != 0)
				w[0] = 1'b1;
			else if (bias == 2 && $urandom_range(0, 3) != 0)
				w[0] = 1'b0;
			send_word(w, i == n - 1);
		end
	endtask

	task automatic test_single_word();
		send_word(32'sh7FFF_FFFF, 1'b1);
		send_word(32'sh8000_0000, 1'b1);
		send_word(-32'sd1, 1'b1);
	endtask

	task automatic test_extremes();
		send_word(32'sh8000_0000, 1'b0);
		send_word(32'sh7FFF_FFFF, 1'b0);
		send_word(-32'sd1, 1'b0);
		send_word(32'sd0, 1'b0);
		send_word(-32'sd2, 1'b0);
		send_word(32'sd1, 1'b1);
	endtask

	task automatic test_one_class();
		send_word(32'sd1, 1'b0);
		send_word(-32'sd1, 1'b0);
		send_word(-32'sd3, 1'b0);
		send_word(32'sh7FFF_FFFF, 1'b1);
		send_word(32'sd0, 1'b0);
		send_word(-32'sd2, 1'b0);
		send_word(32'sh8000_0000, 1'b0);
		send_word(32'sd4, 1'b1);
	endtask

	task automatic test_pairs();
		// even then odd must swap, odd then even stays
		send_word(32'sd2, 1'b0);
		send_word(32'sd3, 1'b1);
		send_word(32'sd3, 1'b0);
		send_word(32'sd2, 1'b1);
	endtask

	task automatic test_capacity();
		send_array(oep_pkg::DEPTH, 0);
	endtask

	task automatic test_overflow();
		// the last item and the one before it are both excess words here
		send_array(oep_pkg::DEPTH + 2, 1);
	endtask

	task automatic test_random_arrays();
		int n;
		int sent;
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			n = $urandom_range(1, 6);
			send_array(n, $urandom_range(0, 2));
			sent += n;
		end
	endtask

	task automatic test_back_to_back();
		gaps_on = 1'b0;
		for (int k = 0; k < 3; k++)
			send_array($urandom_range(1, 4), $urandom_range(0, 2));
	endtask

	initial begin
		valid = 1'b0;
		value = '0;
		last = 1'b0;
		res_ready = 1'b0;
		arst_n = 1'b0;
		gaps_on = 1'b1;
		stall_left = 0;
		held_count = 0;
		held_overflow = 1'b0;
		errors = 0;
		arrays_sent = 0;
		words_sent = 0;
		words_checked = 0;
		cycles = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_word();
		test_extremes();
		test_one_class();
		test_pairs();
		test_capacity();
		test_overflow();
		test_random_arrays();
		test_back_to_back();
		valid <= 1'b0;

		while (partitioned_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d arrays (%0d words), checked %0d partitioned words,",
			arrays_sent, words_sent, words_checked);
		$display("including single-word, full-depth and overflowing arrays; %0d mismatches.",
			errors);
		if (errors == 0)
			$display("odd_even_partition_unit verification clean");
		else
			$display("odd_even_partition_unit verification failed");
		$finish;
	end

endmodule
